### sv/cdt_pkg.sv
// Shared types and constants for the centroid distance tracker.
`timescale 1ns / 1ps

package cdt_pkg;

   localparam int CDT_MAX_TRACKS = 32;
   // Slot numbers travel as 8 bits, enough for the largest table of 256 tracks
   localparam int CDT_SLOT_W = 8;
   localparam int CDT_ID_W = 32;
   localparam int CDT_CTR_W = 16;
   localparam int CDT_LIMIT_W = 20;
   localparam logic [CDT_LIMIT_W-1:0] CDT_LIMIT_RESET = 20'd625;

   localparam logic CDT_CMD_BOX = 1'b0;
   localparam logic CDT_CMD_EOF = 1'b1;

   // Search word passed from cell to cell
   typedef struct packed {
      logic                  live;
      logic                  hit;
      logic [CDT_ID_W-1:0]   hit_id;
      logic [CDT_SLOT_W-1:0] hit_slot;
      logic                  hit_seen;
      logic                  free;
      logic [CDT_SLOT_W-1:0] free_slot;
   } cdt_tok_type;

   // Update broadcast to every cell
   typedef struct packed {
      logic                  prune;
      logic                  upd;
      logic                  alloc;
      logic [CDT_SLOT_W-1:0] slot;
      logic [CDT_ID_W-1:0]   id;
   } cdt_wr_type;

endpackage

### sv/cdt_cell.sv
// One track slot of the tracker chain: holds a track and tests the passing search word.
`timescale 1ns / 1ps

module cdt_cell
   import cdt_pkg::*;
#(
   parameter logic [CDT_SLOT_W-1:0] CELL_IDX = '0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [CDT_LIMIT_W-1:0] limit,
   input  logic [CDT_CTR_W-1:0]   q_cx,
   input  logic [CDT_CTR_W-1:0]   q_cy,
   input  cdt_wr_type             wr,
   input  cdt_tok_type            tok_in,
   output cdt_tok_type            tok_out
);

   logic                 valid_ff, valid_in;
   logic                 seen_ff, seen_in;
   logic [CDT_ID_W-1:0]  id_ff, id_in;
   logic [CDT_CTR_W-1:0] cx_ff, cx_in;
   logic [CDT_CTR_W-1:0] cy_ff, cy_in;
   cdt_tok_type          tok_ff, tok_in_nx;

   logic signed [CDT_CTR_W:0] dx, dy;
   logic [9:0]  mag_x, mag_y;
   logic [19:0] sq_x, sq_y;
   logic [20:0] d2;
   logic        near, match;
   logic        sel;

   assign dx = $signed({q_cx[CDT_CTR_W-1], q_cx}) - $signed({cx_ff[CDT_CTR_W-1], cx_ff});
   assign dy = $signed({q_cy[CDT_CTR_W-1], q_cy}) - $signed({cy_ff[CDT_CTR_W-1], cy_ff});

   // A component of 1024 or more already squares past the largest limit
   assign near = (dx > -17'sd1024) && (dx < 17'sd1024) &&
                 (dy > -17'sd1024) && (dy < 17'sd1024);

   always_comb begin
      logic [CDT_CTR_W:0] ax, ay;
      ax = dx[CDT_CTR_W] ? 17'(-dx) : 17'(dx);
      ay = dy[CDT_CTR_W] ? 17'(-dy) : 17'(dy);
      mag_x = ax[9:0];
      mag_y = ay[9:0];
   end

   assign sq_x  = mag_x * mag_x;
   assign sq_y  = mag_y * mag_y;
   assign d2    = 21'(sq_x) + 21'(sq_y);
   assign match = valid_ff && near && (d2 < {1'b0, limit});

   // On equal ids the earlier slot keeps the win
   assign sel = match && (!tok_in.hit || (id_ff < tok_in.hit_id));

   always_comb begin
      tok_in_nx = tok_in;
      if (sel) begin
         tok_in_nx.hit      = 1'b1;
         tok_in_nx.hit_id   = id_ff;
         tok_in_nx.hit_slot = CELL_IDX;
         tok_in_nx.hit_seen = seen_ff;
      end
      if (!valid_ff && !tok_in.free) begin
         tok_in_nx.free      = 1'b1;
         tok_in_nx.free_slot = CELL_IDX;
      end
      if (!tok_in.live) begin
         tok_in_nx = '0;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      seen_in  = seen_ff;
      id_in    = id_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      if (wr.prune) begin
         valid_in = valid_ff & seen_ff;
         seen_in  = 1'b0;
      end
      if (wr.upd && (wr.slot == CELL_IDX)) begin
         seen_in = 1'b1;
         cx_in   = q_cx;
         cy_in   = q_cy;
      end
      if (wr.alloc && (wr.slot == CELL_IDX)) begin
         valid_in = 1'b1;
         seen_in  = 1'b1;
         id_in    = wr.id;
         cx_in    = q_cx;
         cy_in    = q_cy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         seen_ff  <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         seen_ff  <= seen_in;
         tok_ff   <= tok_in_nx;
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
   end

   assign tok_out = tok_ff;

endmodule

### sv/centroid_distance_tracker_core.sv
// Top level of the centroid distance tracker: control, centre calculation and cell chain.
`timescale 1ns / 1ps

// Channel  Dir  Handshake            Payload
// req      in   req_valid/req_stall  cmd, box_x, box_y, box_w, box_h
// rsp      out  rsp_valid/rsp_stall  track_id, out_x/y/w/h, is_new, duplicate, table_full
// csr      in   csr_wr_en            csr_wr_data (match_dist_sq)
//
// For a box word the search word walks the cell chain one slot per cycle, then the
// result is loaded and the winning slot written back.
// An end-of-frame word prunes every slot in the cycle it is taken and gives no result.
// A waiting result does not block the next request; a result held by rsp_stall holds
// the following box at write-back. Synchronous reset empties the table at once.

module centroid_distance_tracker_core
   import cdt_pkg::*;
#(
   parameter int MAX_TRACKS = CDT_MAX_TRACKS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_cmd,
   input  logic signed [14:0]     req_box_x,
   input  logic signed [14:0]     req_box_y,
   input  logic [13:0]            req_box_w,
   input  logic [13:0]            req_box_h,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [CDT_ID_W-1:0]    rsp_track_id,
   output logic signed [14:0]     rsp_out_x,
   output logic signed [14:0]     rsp_out_y,
   output logic [13:0]            rsp_out_w,
   output logic [13:0]            rsp_out_h,
   output logic                   rsp_is_new,
   output logic                   rsp_duplicate,
   output logic                   rsp_table_full,
   input  logic                   csr_wr_en,
   input  logic [CDT_LIMIT_W-1:0] csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [CDT_LIMIT_W-1:0] limit_ff;
   logic [CDT_ID_W-1:0]    next_id_ff;
   logic                   start_ff;
   logic [CDT_CTR_W-1:0]   q_cx_ff, q_cy_ff;
   logic signed [14:0]     box_x_ff, box_y_ff;
   logic [13:0]            box_w_ff, box_h_ff;
   cdt_tok_type            res_ff;

   logic                   rsp_valid_ff;
   logic [CDT_ID_W-1:0]    rsp_id_ff;
   logic signed [14:0]     rsp_x_ff, rsp_y_ff;
   logic [13:0]            rsp_w_ff, rsp_h_ff;
   logic                   rsp_new_ff, rsp_dup_ff, rsp_full_ff;

   cdt_tok_type tok [MAX_TRACKS+1];
   cdt_wr_type  wr;

   logic accept, commit, out_free;
   logic [CDT_CTR_W-1:0] cx_calc, cy_calc;

   // Centre = (2*edge + size) / 2, truncating toward zero
   function automatic logic [CDT_CTR_W-1:0] centre(input logic signed [14:0] e,
                                                   input logic [13:0] s);
      logic signed [16:0] sum;
      sum = $signed({e[14], e, 1'b0}) + $signed({3'b000, s});
      if (sum[16]) begin
         sum = sum + 17'sd1;
      end
      centre = sum[16:1];
   endfunction

   assign cx_calc = centre(req_box_x, req_box_w);
   assign cy_calc = centre(req_box_y, req_box_h);

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign commit    = (state_ff == ST_DONE) && out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_cmd == CDT_CMD_BOX)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (tok[MAX_TRACKS].live) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      wr       = '0;
      wr.prune = accept && (req_cmd == CDT_CMD_EOF);
      wr.upd   = commit && res_ff.hit;
      wr.alloc = commit && !res_ff.hit && res_ff.free;
      wr.slot  = res_ff.hit ? res_ff.hit_slot : res_ff.free_slot;
      wr.id    = next_id_ff;
   end

   always_comb begin
      tok[0]      = '0;
      tok[0].live = start_ff;
   end

   for (genvar i = 0; i < MAX_TRACKS; i++) begin : g_cell
      cdt_cell #(
         .CELL_IDX (CDT_SLOT_W'(i))
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .limit   (limit_ff),
         .q_cx    (q_cx_ff),
         .q_cy    (q_cy_ff),
         .wr      (wr),
         .tok_in  (tok[i]),
         .tok_out (tok[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= CDT_LIMIT_RESET;
         next_id_ff   <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= accept && (req_cmd == CDT_CMD_BOX);
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (commit && !res_ff.hit) begin
            next_id_ff <= next_id_ff + 1'b1;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_cx_ff  <= cx_calc;
         q_cy_ff  <= cy_calc;
         box_x_ff <= req_box_x;
         box_y_ff <= req_box_y;
         box_w_ff <= req_box_w;
         box_h_ff <= req_box_h;
      end
      if (tok[MAX_TRACKS].live) begin
         res_ff <= tok[MAX_TRACKS];
      end
      if (commit) begin
         rsp_id_ff   <= res_ff.hit ? res_ff.hit_id : next_id_ff;
         rsp_x_ff    <= box_x_ff;
         rsp_y_ff    <= box_y_ff;
         rsp_w_ff    <= box_w_ff;
         rsp_h_ff    <= box_h_ff;
         rsp_new_ff  <= !res_ff.hit;
         rsp_dup_ff  <= res_ff.hit && res_ff.hit_seen;
         rsp_full_ff <= !res_ff.hit && !res_ff.free;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_track_id   = rsp_id_ff;
   assign rsp_out_x      = rsp_x_ff;
   assign rsp_out_y      = rsp_y_ff;
   assign rsp_out_w      = rsp_w_ff;
   assign rsp_out_h      = rsp_h_ff;
   assign rsp_is_new     = rsp_new_ff;
   assign rsp_duplicate  = rsp_dup_ff;
   assign rsp_table_full = rsp_full_ff;

endmodule
